[rtl/announce_transmit_scheduler_top_macros.svh]
// Assertion macros shared by the announce transmit scheduler RTL.
`ifndef ANNOUNCE_TRANSMIT_SCHEDULER_TOP_MACROS_SVH
`define ANNOUNCE_TRANSMIT_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ATS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ats assertion failed");
`define ATS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ats assertion failed");
`else
`define ATS_ASSERT_IMPL(lbl, ante, cons)
`define ATS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/ats_pkg.sv]
// Types, constants and microprogram of the announce transmit scheduler.
`default_nettype none
package ats_pkg;

	localparam int TIME_W  = 64;
	localparam int SEQ_W   = 16;
	localparam int FLAG_W  = 6;
	localparam int TLV_W   = 11;
	localparam int COUNT_W = 8;
	localparam int ST_W    = 3;

	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ANN_INT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OLD_INT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RCPT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_CFG  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TFLAGS   = 3'd4;

	localparam logic [TIME_W-1:0]  RESET_INTERVAL_NS = 64'd1_000_000_000;
	localparam logic [COUNT_W-1:0] RESET_RCPT        = 8'd3;

	localparam int MAX_PATH_ENTRIES = 32;
	localparam int MAX_PASSES       = 8;
	localparam int PASS_W           = $clog2(MAX_PASSES);

	// 25 ms = 2^6 * 390625: low bits by shift, odd factor by remainder unit
	localparam int ALIGN_NS    = 25_000_000;
	localparam int ALIGN_SHIFT = 6;
	localparam int ALIGN_ODD   = ALIGN_NS / (1 << ALIGN_SHIFT);
	localparam int REM_W       = $clog2(ALIGN_ODD);
	localparam logic [REM_W:0] ALIGN_ODD_V = (REM_W+1)'(ALIGN_ODD);
	localparam int QUOT_W      = TIME_W - ALIGN_SHIFT;
	localparam int DIGIT_W     = 4;
	localparam int MOD_STEPS   = (QUOT_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MOD_PAD_W   = MOD_STEPS * DIGIT_W;
	localparam int MOD_CNT_W   = $clog2(MOD_STEPS + 1);

	localparam logic [ST_W-1:0] ST_INIT     = 3'd0;
	localparam logic [ST_W-1:0] ST_TX_INIT  = 3'd1;
	localparam logic [ST_W-1:0] ST_IDLE     = 3'd2;
	localparam logic [ST_W-1:0] ST_PERIODIC = 3'd3;
	localparam logic [ST_W-1:0] ST_ANNOUNCE = 3'd4;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
	localparam logic [OP_W-1:0] OP_PASS     = 4'd2;
	localparam logic [OP_W-1:0] OP_INIT     = 4'd3;
	localparam logic [OP_W-1:0] OP_TXINIT   = 4'd4;
	localparam logic [OP_W-1:0] OP_ADD      = 4'd5;
	localparam logic [OP_W-1:0] OP_MSTART   = 4'd6;
	localparam logic [OP_W-1:0] OP_SETT     = 4'd7;
	localparam logic [OP_W-1:0] OP_DECIDE   = 4'd8;
	localparam logic [OP_W-1:0] OP_PERIODIC = 4'd9;
	localparam logic [OP_W-1:0] OP_ANNOUNCE = 4'd10;
	localparam logic [OP_W-1:0] OP_CHECK    = 4'd11;
	localparam logic [OP_W-1:0] OP_EMIT     = 4'd12;

	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_NEXT   = 3'd0;
	localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
	localparam logic [COND_W-1:0] C_NOACC  = 3'd2;
	localparam logic [COND_W-1:0] C_DISP   = 3'd3;
	localparam logic [COND_W-1:0] C_NOTENT = 3'd4;
	localparam logic [COND_W-1:0] C_MBUSY  = 3'd5;
	localparam logic [COND_W-1:0] C_MORE   = 3'd6;
	localparam logic [COND_W-1:0] C_OBUSY  = 3'd7;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_WAIT   = 4'd0;
	localparam logic [STEP_W-1:0] S_PASS   = 4'd1;
	localparam logic [STEP_W-1:0] S_INIT   = 4'd2;
	localparam logic [STEP_W-1:0] S_TXI    = 4'd3;
	localparam logic [STEP_W-1:0] S_IDLE   = 4'd4;
	localparam logic [STEP_W-1:0] S_ADD    = 4'd5;
	localparam logic [STEP_W-1:0] S_MSTART = 4'd6;
	localparam logic [STEP_W-1:0] S_MWAIT  = 4'd7;
	localparam logic [STEP_W-1:0] S_SETT   = 4'd8;
	localparam logic [STEP_W-1:0] S_DECIDE = 4'd9;
	localparam logic [STEP_W-1:0] S_PER    = 4'd10;
	localparam logic [STEP_W-1:0] S_ANN    = 4'd11;
	localparam logic [STEP_W-1:0] S_HOLD   = 4'd12;
	localparam logic [STEP_W-1:0] S_CHECK  = 4'd13;
	localparam logic [STEP_W-1:0] S_EMIT   = 4'd14;
	localparam logic [STEP_W-1:0] S_LAST   = S_EMIT;

	typedef struct packed {
		logic              take;
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic            accept;
		logic            entered;
		logic            mod_busy;
		logic            more;
		logic            out_busy;
		logic [ST_W-1:0] state;
	} stat_t;

	function automatic ctl_t cw(input logic take, input logic [OP_W-1:0] op,
		input logic [COND_W-1:0] cond, input logic [STEP_W-1:0] target);
		ctl_t c;
		c.take   = take;
		c.op     = op;
		c.cond   = cond;
		c.target = target;
		return c;
	endfunction

	function automatic ctl_t prog_rom(input logic [STEP_W-1:0] step);
		ctl_t c;
		case (step)
			S_WAIT:   c = cw(1'b1, OP_LOAD,     C_NOACC,  S_WAIT);
			S_PASS:   c = cw(1'b0, OP_PASS,     C_DISP,   S_HOLD);
			S_INIT:   c = cw(1'b0, OP_INIT,     C_ALWAYS, S_CHECK);
			S_TXI:    c = cw(1'b0, OP_TXINIT,   C_ALWAYS, S_CHECK);
			S_IDLE:   c = cw(1'b0, OP_NOP,      C_NOTENT, S_DECIDE);
			S_ADD:    c = cw(1'b0, OP_ADD,      C_NEXT,   S_WAIT);
			S_MSTART: c = cw(1'b0, OP_MSTART,   C_NEXT,   S_WAIT);
			S_MWAIT:  c = cw(1'b0, OP_NOP,      C_MBUSY,  S_MWAIT);
			S_SETT:   c = cw(1'b0, OP_SETT,     C_NEXT,   S_WAIT);
			S_DECIDE: c = cw(1'b0, OP_DECIDE,   C_ALWAYS, S_CHECK);
			S_PER:    c = cw(1'b0, OP_PERIODIC, C_ALWAYS, S_CHECK);
			S_ANN:    c = cw(1'b0, OP_ANNOUNCE, C_ALWAYS, S_CHECK);
			S_HOLD:   c = cw(1'b0, OP_NOP,      C_ALWAYS, S_CHECK);
			S_CHECK:  c = cw(1'b0, OP_CHECK,    C_MORE,   S_PASS);
			S_EMIT:   c = cw(1'b0, OP_EMIT,     C_OBUSY,  S_EMIT);
			default:  c = cw(1'b0, OP_NOP,      C_ALWAYS, S_WAIT);
		endcase
		return c;
	endfunction

	function automatic logic [STEP_W-1:0] dispatch(input logic [ST_W-1:0] st);
		logic [STEP_W-1:0] s;
		case (st)
			ST_INIT:     s = S_INIT;
			ST_TX_INIT:  s = S_TXI;
			ST_IDLE:     s = S_IDLE;
			ST_PERIODIC: s = S_PER;
			ST_ANNOUNCE: s = S_ANN;
			default:     s = S_HOLD;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[rtl/ats_if.sv]
// Tick and report channel interfaces of the announce transmit scheduler.
`default_nettype none
interface ats_tick_if;
	logic        valid;
	logic        ready;
	logic [63:0] now_ns;
	logic        begin_pulse;
	logic        instance_on;
	logic        port_capable;
	logic        is_master_port;
	logic        port_selected;
	logic        update_pending;
	logic        asymmetry_mode;
	logic        set_new_info;
	logic        set_slowdown;
	logic [7:0]  path_count;

	modport source (output valid, now_ns, begin_pulse, instance_on, port_capable,
		is_master_port, port_selected, update_pending, asymmetry_mode,
		set_new_info, set_slowdown, path_count, input ready);
	modport sink (input valid, now_ns, begin_pulse, instance_on, port_capable,
		is_master_port, port_selected, update_pending, asymmetry_mode,
		set_new_info, set_slowdown, path_count, output ready);
endinterface

interface ats_report_if;
	logic        valid;
	logic        ready;
	logic        send_announce;
	logic [15:0] sequence_number;
	logic [5:0]  flags_byte;
	logic [10:0] tlv_length;
	logic [63:0] next_send_ns;
	logic        new_info_flag;
	logic        slowdown_flag;

	modport source (output valid, send_announce, sequence_number, flags_byte,
		tlv_length, next_send_ns, new_info_flag, slowdown_flag, input ready);
	modport sink (input valid, send_announce, sequence_number, flags_byte,
		tlv_length, next_send_ns, new_info_flag, slowdown_flag, output ready);
endinterface
`default_nettype wire

[rtl/announce_transmit_scheduler_top.sv]
// Top level of the announce transmit scheduler.
//
// One tick transaction in, one report transaction out. Each tick runs the
// port announce state machine through up to eight chained state passes,
// sequenced by a 15-step microprogram over a shared datapath. A tick is
// accepted in the wait step and ends by loading the report in the emit
// step; a pass runs a dispatch step, the step of its state and a check
// step. A pass that enters idle also adds the interval to the time and
// waits on a remainder unit, since the next send time is rounded down to
// 25 ms by that unit, which takes 4 bits per cycle over 58 bits.
// While the output register still holds an unaccepted report, the last
// step waits. The next tick is taken as soon as the report has been
// loaded into the output register, even while that report still waits.
// Configuration is a write port (index, 64-bit data); writes to unused
// indexes are ignored.
`default_nettype none
module announce_transmit_scheduler_top
	import ats_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	ats_tick_if.sink                  tick,
	ats_report_if.source              report
);

	ctl_t  ctl;
	stat_t stat;

	ats_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	ats_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick),
		.report    (report),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule
`default_nettype wire

[rtl/ats_mod.sv]
// Remainder unit: value mod the odd factor of 25 ms, four bits per cycle.
`default_nettype none
`include "announce_transmit_scheduler_top_macros.svh"
module ats_mod
	import ats_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [QUOT_W-1:0] value,
	output logic                   busy,
	output logic [REM_W-1:0]       rem
);

	logic [MOD_PAD_W-1:0] sh_q;
	logic [REM_W-1:0]     rem_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [REM_W:0]       rem_nxt;

	always_comb begin
		logic [REM_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < DIGIT_W; i++) begin
			r = {r[REM_W-1:0], sh_q[MOD_PAD_W-1-i]};
			if (r >= ALIGN_ODD_V) begin
				r = r - ALIGN_ODD_V;
			end
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
		end else if (start) begin
			cnt_q <= MOD_CNT_W'(MOD_STEPS);
			rem_q <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q - MOD_CNT_W'(1);
			rem_q <= rem_nxt[REM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= MOD_PAD_W'(value);
		end else if (busy) begin
			sh_q <= {sh_q[MOD_PAD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign busy = cnt_q != '0;
	assign rem  = rem_q;

	`ATS_ASSERT_IMPL(a_rem_bound, 1'b1, {1'b0, rem_q} < ALIGN_ODD_V)

endmodule
`default_nettype wire

[rtl/ats_seq.sv]
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none
`include "announce_transmit_scheduler_top_macros.svh"
module ats_seq
	import ats_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output ctl_t       ctl
);

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_nxt;
	logic              jump;

	assign ctl = prog_rom(pc_q);

	always_comb begin
		case (ctl.cond)
			C_NEXT:   jump = 1'b0;
			C_ALWAYS: jump = 1'b1;
			C_NOACC:  jump = !stat.accept;
			C_NOTENT: jump = !stat.entered;
			C_MBUSY:  jump = stat.mod_busy;
			C_MORE:   jump = stat.more;
			C_OBUSY:  jump = stat.out_busy;
			default:  jump = 1'b0;
		endcase
		if (ctl.cond == C_DISP) begin
			pc_nxt = dispatch(stat.state);
		end else if (jump) begin
			pc_nxt = ctl.target;
		end else if (pc_q == S_LAST) begin
			pc_nxt = S_WAIT;
		end else begin
			pc_nxt = pc_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	`ATS_ASSERT_NEXT(a_accept_starts_pass, stat.accept, pc_q == S_PASS)
	`ATS_ASSERT_IMPL(a_take_only_waiting, ctl.take, pc_q == S_WAIT)

endmodule
`default_nettype wire

[rtl/ats_dp.sv]
// Datapath: port state, scheduling arithmetic, configuration and report register.
`default_nettype none
`include "announce_transmit_scheduler_top_macros.svh"
module ats_dp
	import ats_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	ats_tick_if.sink                  tick,
	ats_report_if.source              report,
	input  wire ctl_t                 ctl,
	output stat_t                     stat
);

	logic [TIME_W-1:0]  ann_int_q;
	logic [TIME_W-1:0]  old_int_q;
	logic [COUNT_W-1:0] rcpt_q;
	logic               ext_q;
	logic [FLAG_W-1:0]  tflag_q;

	logic [ST_W-1:0]    state_q;
	logic [ST_W-1:0]    prev_q;
	logic               info_q;
	logic               slowdown_q;
	logic [TIME_W-1:0]  send_time_q;
	logic [TIME_W-1:0]  cur_int_q;
	logic [COUNT_W-1:0] slow_cnt_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [FLAG_W-1:0]  flag_q;

	logic               sent_q;
	logic [TLV_W-1:0]   tlv_q;
	logic               entered_q;
	logic [PASS_W-1:0]  pass_q;

	logic [TIME_W-1:0]  now_q;
	logic               master_q;
	logic               sel_ok_q;
	logic               asym_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  sum_q;

	logic               out_valid_q;

	logic               accept;
	logic               emit;
	logic               out_busy;
	logic               force_txi;
	logic [TIME_W:0]    sum_ext;
	logic [TIME_W-1:0]  sum_sat;
	logic               now_lt;
	logic               more;
	logic               mod_busy;
	logic [REM_W-1:0]   mod_rem;
	logic [QUOT_W-1:0]  quot;

	assign accept    = tick.valid && ctl.take;
	assign tick.ready = ctl.take;
	assign out_busy  = out_valid_q && !report.ready;
	assign emit      = (ctl.op == OP_EMIT) && !out_busy;
	assign force_txi = tick.begin_pulse || !tick.instance_on || !tick.port_capable;
	assign sum_ext   = {1'b0, now_q} + {1'b0, cur_int_q};
	assign sum_sat   = sum_ext[TIME_W] ? '1 : sum_ext[TIME_W-1:0];
	assign now_lt    = now_q < send_time_q;
	assign quot      = sum_q[TIME_W-1:ALIGN_SHIFT] - QUOT_W'(mod_rem);
	assign more      = !sent_q && (prev_q != state_q) &&
		(pass_q != PASS_W'(MAX_PASSES - 1));

	ats_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.op == OP_MSTART),
		.value  (sum_q[TIME_W-1:ALIGN_SHIFT]),
		.busy   (mod_busy),
		.rem    (mod_rem)
	);

	always_comb begin
		stat.accept   = accept;
		stat.entered  = entered_q;
		stat.mod_busy = mod_busy;
		stat.more     = more;
		stat.out_busy = out_busy;
		stat.state    = state_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ann_int_q <= RESET_INTERVAL_NS;
			old_int_q <= RESET_INTERVAL_NS;
			rcpt_q    <= RESET_RCPT;
			ext_q     <= 1'b0;
			tflag_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANN_INT: ann_int_q <= cfg_data;
				REG_OLD_INT: old_int_q <= cfg_data;
				REG_RCPT:    rcpt_q    <= cfg_data[COUNT_W-1:0];
				REG_EXT_CFG: ext_q     <= cfg_data[0];
				REG_TFLAGS:  tflag_q   <= cfg_data[FLAG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			prev_q      <= ST_INIT;
			info_q      <= 1'b0;
			slowdown_q  <= 1'b0;
			send_time_q <= '0;
			cur_int_q   <= RESET_INTERVAL_NS;
			slow_cnt_q  <= '0;
			seq_q       <= '0;
			flag_q      <= '0;
			sent_q      <= 1'b0;
			tlv_q       <= '0;
			entered_q   <= 1'b0;
			pass_q      <= '0;
		end else begin
			case (ctl.op)
				OP_LOAD: begin
					if (accept) begin
						if (tick.set_new_info) info_q <= 1'b1;
						if (tick.set_slowdown) slowdown_q <= 1'b1;
						if (force_txi) state_q <= ST_TX_INIT;
						sent_q <= 1'b0;
						tlv_q  <= '0;
						pass_q <= '0;
					end
				end
				OP_PASS: begin
					entered_q <= prev_q != state_q;
					prev_q    <= state_q;
				end
				OP_INIT: state_q <= ST_TX_INIT;
				OP_TXINIT: begin
					if (entered_q) begin
						info_q     <= 1'b1;
						slowdown_q <= 1'b0;
						slow_cnt_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				OP_PERIODIC: begin
					if (entered_q && master_q) info_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				OP_SETT: send_time_q <= {quot, {ALIGN_SHIFT{1'b0}}};
				OP_DECIDE: begin
					if (info_q && master_q && now_lt && (sel_ok_q || ext_q) && !asym_q) begin
						state_q <= ST_ANNOUNCE;
					end else if (!now_lt && (sel_ok_q || !ext_q)) begin
						state_q <= ST_PERIODIC;
					end
				end
				OP_ANNOUNCE: begin
					if (entered_q) begin
						info_q     <= 1'b0;
						seq_q      <= seq_q + SEQ_W'(1);
						flag_q     <= flag_q | tflag_q;
						tlv_q      <= (count_q <= COUNT_W'(MAX_PATH_ENTRIES)) ?
							TLV_W'({count_q, 3'b000}) : '0;
						if (slowdown_q) begin
							if (slow_cnt_q >= rcpt_q) begin
								cur_int_q  <= ann_int_q;
								slow_cnt_q <= '0;
								slowdown_q <= 1'b0;
							end else begin
								cur_int_q  <= old_int_q;
								slow_cnt_q <= slow_cnt_q + COUNT_W'(1);
							end
						end else begin
							slow_cnt_q <= '0;
							cur_int_q  <= ann_int_q;
						end
						sent_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				OP_CHECK: pass_q <= pass_q + PASS_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= tick.now_ns;
			master_q <= tick.is_master_port;
			sel_ok_q <= tick.port_selected && !tick.update_pending;
			asym_q   <= tick.asymmetry_mode;
			count_q  <= tick.path_count;
		end
		if (ctl.op == OP_ADD) begin
			sum_q <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			report.send_announce   <= sent_q;
			report.sequence_number <= seq_q;
			report.flags_byte      <= flag_q;
			report.tlv_length      <= tlv_q;
			report.next_send_ns    <= send_time_q;
			report.new_info_flag   <= info_q;
			report.slowdown_flag   <= slowdown_q;
		end
	end

	assign report.valid = out_valid_q;

	`ATS_ASSERT_IMPL(a_send_time_aligned, 1'b1, send_time_q[ALIGN_SHIFT-1:0] == '0)
	`ATS_ASSERT_IMPL(a_seq_on_announce, seq_q != $past(seq_q), $past(ctl.op) == OP_ANNOUNCE)

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the announce transmit scheduler top level.
`timescale 1ns / 1ps

module testbench
	import ats_pkg::*;
();

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_PAD = 120;
	localparam int PHASE_ITEMS = 340;
	localparam logic [TIME_W-1:0] MS = 64'd1_000_000;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [8:0] F_BEGIN   = 9'h100;
	localparam logic [8:0] F_INST    = 9'h080;
	localparam logic [8:0] F_CAP     = 9'h040;
	localparam logic [8:0] F_MASTER  = 9'h020;
	localparam logic [8:0] F_SEL     = 9'h010;
	localparam logic [8:0] F_UPDT    = 9'h008;
	localparam logic [8:0] F_ASYM    = 9'h004;
	localparam logic [8:0] F_NEWINFO = 9'h002;
	localparam logic [8:0] F_SLOW    = 9'h001;
	localparam logic [8:0] F_RUN     = F_INST | F_CAP | F_MASTER | F_SEL;

	typedef struct packed {
		logic [TIME_W-1:0]  now_ns;
		logic               begin_pulse;
		logic               instance_on;
		logic               port_capable;
		logic               is_master_port;
		logic               port_selected;
		logic               update_pending;
		logic               asymmetry_mode;
		logic               set_new_info;
		logic               set_slowdown;
		logic [COUNT_W-1:0] path_count;
	} tick_item_t;

	typedef struct packed {
		logic              send_announce;
		logic [SEQ_W-1:0]  sequence_number;
		logic [FLAG_W-1:0] flags_byte;
		logic [TLV_W-1:0]  tlv_length;
		logic [TIME_W-1:0] next_send_ns;
		logic              new_info_flag;
		logic              slowdown_flag;
	} report_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ats_tick_if tick_ch();
	ats_report_if report_ch();

	announce_transmit_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick(tick_ch),
		.report(report_ch)
	);

	// port announce machine and its registers, as the block should hold them
	logic [TIME_W-1:0]  ann_interval;
	logic [TIME_W-1:0]  old_interval;
	logic [COUNT_W-1:0] rcpt_timeout;
	logic               ext_cfg;
	logic [FLAG_W-1:0]  time_flags;
	logic [ST_W-1:0]    port_state;
	logic [ST_W-1:0]    port_prev_state;
	logic               info_pending;
	logic               slowdown;
	logic [TIME_W-1:0]  send_time;
	logic [TIME_W-1:0]  cur_interval;
	logic [COUNT_W-1:0] slow_count;
	logic [SEQ_W-1:0]   seq_id;
	logic [FLAG_W-1:0]  flag_acc;

	tick_item_t pending_ticks[$];
	report_item_t expected_reports[$];
	tick_item_t next_tick;
	tick_item_t seen_tick;
	report_item_t want;
	report_item_t got;
	logic tick_taken;
	logic steady;
	logic [TIME_W-1:0] base_ns;
	int errors;
	int cycle_count;

	function automatic report_item_t step_announce_port(input tick_item_t t);
		report_item_t r;
		logic sent;
		logic entered;
		logic sel_ok;
		logic [TLV_W-1:0] tlv;
		logic [TIME_W:0] sum;
		logic [TIME_W-1:0] sat;
		int pass;
		sent = 1'b0;
		tlv = '0;
		if (t.set_new_info)
			info_pending = 1'b1;
		if (t.set_slowdown)
			slowdown = 1'b1;
		if (t.begin_pulse || !t.instance_on || !t.port_capable)
			port_state = ST_TX_INIT;
		for (pass = 0; pass < MAX_PASSES; pass++) begin
			entered = port_prev_state != port_state;
			sel_ok = t.port_selected && !t.update_pending;
			port_prev_state = port_state;
			case (port_state)
				ST_INIT: begin
					port_state = ST_TX_INIT;
				end
				ST_TX_INIT: begin
					if (entered) begin
						info_pending = 1'b1;
						slowdown = 1'b0;
						slow_count = '0;
					end
					port_state = ST_IDLE;
				end
				ST_PERIODIC: begin
					if (entered)
						info_pending = info_pending || t.is_master_port;
					port_state = ST_IDLE;
				end
				ST_IDLE: begin
					if (entered) begin
						sum = {1'b0, t.now_ns} + {1'b0, cur_interval};
						sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
						send_time = (sat / TIME_W'(ALIGN_NS)) * TIME_W'(ALIGN_NS);
					end
					if (info_pending && t.is_master_port && t.now_ns < send_time &&
						(sel_ok || ext_cfg) && !t.asymmetry_mode)
						port_state = ST_ANNOUNCE;
					else if (t.now_ns >= send_time && (sel_ok || !ext_cfg))
						port_state = ST_PERIODIC;
				end
				ST_ANNOUNCE: begin
					if (entered) begin
						info_pending = 1'b0;
						seq_id = seq_id + SEQ_W'(1);
						flag_acc = flag_acc | time_flags;
						tlv = (t.path_count <= MAX_PATH_ENTRIES) ?
							TLV_W'(8 * t.path_count) : '0;
						if (slowdown) begin
							if (slow_count >= rcpt_timeout) begin
								cur_interval = ann_interval;
								slow_count = '0;
								slowdown = 1'b0;
							end else begin
								cur_interval = old_interval;
								slow_count = slow_count + COUNT_W'(1);
							end
						end else begin
							slow_count = '0;
							cur_interval = ann_interval;
						end
						sent = 1'b1;
					end
					port_state = ST_IDLE;
				end
				default: begin
				end
			endcase
			if (sent)
				break;
			if (port_prev_state == port_state)
				break;
		end
		r.send_announce = sent;
		r.sequence_number = seq_id;
		r.flags_byte = flag_acc;
		r.tlv_length = tlv;
		r.next_send_ns = send_time;
		r.new_info_flag = info_pending;
		r.slowdown_flag = slowdown;
		return r;
	endfunction

	function automatic tick_item_t make_tick(input logic [TIME_W-1:0] now,
		input logic [8:0] ctl, input logic [COUNT_W-1:0] count);
		tick_item_t t;
		t.now_ns = now;
		{t.begin_pulse, t.instance_on, t.port_capable, t.is_master_port, t.port_selected,
			t.update_pending, t.asymmetry_mode, t.set_new_info, t.set_slowdown} = ctl;
		t.path_count = count;
		return t;
	endfunction

	// mostly a running port with time moving forward; some fully random ticks
	function automatic tick_item_t random_tick();
		tick_item_t t;
		logic [8:0] ctl;
		if ($urandom_range(99) < 12)
			return make_tick({$urandom, $urandom}, 9'($urandom), 8'($urandom));
		case ($urandom_range(39))
			0: base_ns = {$urandom, $urandom};
			1: base_ns = TIME_MAX - TIME_W'($urandom_range(200_000_000));
			2: base_ns = base_ns;
			default: base_ns = base_ns + TIME_W'($urandom_range(90_000_000));
		endcase
		ctl = '0;
		ctl |= ($urandom_range(59) == 0) ? F_BEGIN : '0;
		ctl |= ($urandom_range(39) != 0) ? F_INST : '0;
		ctl |= ($urandom_range(39) != 0) ? F_CAP : '0;
		ctl |= ($urandom_range(9) < 8) ? F_MASTER : '0;
		ctl |= ($urandom_range(9) != 0) ? F_SEL : '0;
		ctl |= ($urandom_range(9) == 0) ? F_UPDT : '0;
		ctl |= ($urandom_range(9) == 0) ? F_ASYM : '0;
		ctl |= ($urandom_range(6) == 0) ? F_NEWINFO : '0;
		ctl |= ($urandom_range(4) == 0) ? F_SLOW : '0;
		t = make_tick(base_ns, ctl, ($urandom_range(3) == 0) ? 8'($urandom) :
			8'($urandom_range(MAX_PATH_ENTRIES + 2)));
		return t;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] seen,
		input logic [63:0] exp);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, seen, exp);
		errors++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_ANN_INT: ann_interval = val;
			REG_OLD_INT: old_interval = val;
			REG_RCPT:    rcpt_timeout = val[COUNT_W-1:0];
			REG_EXT_CFG: ext_cfg = val[0];
			REG_TFLAGS:  time_flags = val[FLAG_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [63:0] ann, input logic [63:0] old,
		input logic [63:0] rcpt, input logic [63:0] ext, input logic [63:0] flags);
		write_reg(REG_ANN_INT, ann);
		write_reg(REG_OLD_INT, old);
		write_reg(REG_RCPT, rcpt);
		write_reg(REG_EXT_CFG, ext);
		write_reg(REG_TFLAGS, flags);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_ticks.size() != 0 || tick_ch.valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// driver: presents pending ticks at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!tick_ch.valid || tick_taken) begin
				if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
					next_tick = pending_ticks.pop_front();
					tick_ch.valid <= 1'b1;
					tick_ch.now_ns <= next_tick.now_ns;
					tick_ch.begin_pulse <= next_tick.begin_pulse;
					tick_ch.instance_on <= next_tick.instance_on;
					tick_ch.port_capable <= next_tick.port_capable;
					tick_ch.is_master_port <= next_tick.is_master_port;
					tick_ch.port_selected <= next_tick.port_selected;
					tick_ch.update_pending <= next_tick.update_pending;
					tick_ch.asymmetry_mode <= next_tick.asymmetry_mode;
					tick_ch.set_new_info <= next_tick.set_new_info;
					tick_ch.set_slowdown <= next_tick.set_slowdown;
					tick_ch.path_count <= next_tick.path_count;
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
			report_ch.ready <= steady || ($urandom_range(99) >= 9);
		end
	end

	// monitor: checks reports first, then predicts for the accepted tick
	always @(posedge clk) begin
		if (arst_n) begin
			tick_taken <= tick_ch.valid && tick_ch.ready;
			if (report_ch.valid && report_ch.ready) begin
				got.send_announce = report_ch.send_announce;
				got.sequence_number = report_ch.sequence_number;
				got.flags_byte = report_ch.flags_byte;
				got.tlv_length = report_ch.tlv_length;
				got.next_send_ns = report_ch.next_send_ns;
				got.new_info_flag = report_ch.new_info_flag;
				got.slowdown_flag = report_ch.slowdown_flag;
				if (expected_reports.size() == 0) begin
					report_mismatch("report with no tick pending", got.sequence_number, 0);
				end else begin
					want = expected_reports.pop_front();
					if (got.send_announce !== want.send_announce)
						report_mismatch("send_announce", got.send_announce, want.send_announce);
					if (got.sequence_number !== want.sequence_number)
						report_mismatch("sequence_number", got.sequence_number,
							want.sequence_number);
					if (got.flags_byte !== want.flags_byte)
						report_mismatch("flags_byte", got.flags_byte, want.flags_byte);
					if (got.tlv_length !== want.tlv_length)
						report_mismatch("tlv_length", got.tlv_length, want.tlv_length);
					if (got.next_send_ns !== want.next_send_ns)
						report_mismatch("next_send_ns", got.next_send_ns, want.next_send_ns);
					if (got.new_info_flag !== want.new_info_flag)
						report_mismatch("new_info_flag", got.new_info_flag, want.new_info_flag);
					if (got.slowdown_flag !== want.slowdown_flag)
						report_mismatch("slowdown_flag", got.slowdown_flag, want.slowdown_flag);
				end
			end
			if (tick_ch.valid && tick_ch.ready) begin
				seen_tick.now_ns = tick_ch.now_ns;
				seen_tick.begin_pulse = tick_ch.begin_pulse;
				seen_tick.instance_on = tick_ch.instance_on;
				seen_tick.port_capable = tick_ch.port_capable;
				seen_tick.is_master_port = tick_ch.is_master_port;
				seen_tick.port_selected = tick_ch.port_selected;
				seen_tick.update_pending = tick_ch.update_pending;
				seen_tick.asymmetry_mode = tick_ch.asymmetry_mode;
				seen_tick.set_new_info = tick_ch.set_new_info;
				seen_tick.set_slowdown = tick_ch.set_slowdown;
				seen_tick.path_count = tick_ch.path_count;
				expected_reports.push_back(step_announce_port(seen_tick));
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.now_ns = '0;
		tick_ch.begin_pulse = 1'b0;
		tick_ch.instance_on = 1'b0;
		tick_ch.port_capable = 1'b0;
		tick_ch.is_master_port = 1'b0;
		tick_ch.port_selected = 1'b0;
		tick_ch.update_pending = 1'b0;
		tick_ch.asymmetry_mode = 1'b0;
		tick_ch.set_new_info = 1'b0;
		tick_ch.set_slowdown = 1'b0;
		tick_ch.path_count = '0;
		report_ch.ready = 1'b0;
		tick_taken = 1'b0;
		steady = 1'b0;
		errors = 0;
		cycle_count = 0;
		base_ns = '0;
		ann_interval = RESET_INTERVAL_NS;
		old_interval = RESET_INTERVAL_NS;
		rcpt_timeout = RESET_RCPT;
		ext_cfg = 1'b0;
		time_flags = '0;
		port_state = ST_INIT;
		port_prev_state = ST_INIT;
		info_pending = 1'b0;
		slowdown = 1'b0;
		send_time = '0;
		cur_interval = RESET_INTERVAL_NS;
		slow_count = '0;
		seq_id = '0;
		flag_acc = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(100 * MS, 200 * MS, 2, 0, 6'h15);
		pending_ticks.push_back(make_tick(0, F_RUN, 0));
		pending_ticks.push_back(make_tick(10 * MS, F_RUN, 32));
		pending_ticks.push_back(make_tick(100 * MS, F_RUN, 33));
		pending_ticks.push_back(make_tick(150 * MS, F_RUN | F_NEWINFO, 32));
		pending_ticks.push_back(make_tick(150 * MS, F_RUN | F_NEWINFO | F_ASYM, 5));
		pending_ticks.push_back(make_tick(160 * MS, F_RUN | F_UPDT, 5));
		pending_ticks.push_back(make_tick(170 * MS, F_RUN & ~F_SEL, 1));
		pending_ticks.push_back(make_tick(180 * MS, (F_RUN & ~F_MASTER) | F_NEWINFO, 2));
		pending_ticks.push_back(make_tick(200 * MS, F_RUN, 255));
		pending_ticks.push_back(make_tick(210 * MS, F_RUN | F_SLOW, 0));
		pending_ticks.push_back(make_tick(220 * MS, F_RUN | F_SLOW | F_NEWINFO, 1));
		pending_ticks.push_back(make_tick(230 * MS, F_RUN | F_NEWINFO, 2));
		pending_ticks.push_back(make_tick(240 * MS, F_RUN | F_NEWINFO, 3));
		pending_ticks.push_back(make_tick(250 * MS, F_RUN | F_NEWINFO, 4));
		pending_ticks.push_back(make_tick(260 * MS, F_RUN | F_BEGIN, 8));
		pending_ticks.push_back(make_tick(270 * MS, F_RUN & ~F_INST, 8));
		pending_ticks.push_back(make_tick(280 * MS, F_RUN & ~F_CAP, 8));
		pending_ticks.push_back(make_tick(TIME_MAX - 15, F_RUN | F_BEGIN, 3));
		pending_ticks.push_back(make_tick(TIME_MAX, F_RUN, 3));
		pending_ticks.push_back(make_tick(0, F_RUN | F_BEGIN, 0));
		pending_ticks.push_back(make_tick(0, '0, 0));
		drain();

		for (int phase = 1; phase <= 6; phase++) begin
			case (phase)
				1: configure(50 * MS, 75 * MS, 0, 1, 6'h3F);
				2: configure(0, 0, 255, 0, 0);
				3: configure(TIME_MAX, TIME_MAX, 1, 1, $urandom_range(63));
				4: configure($urandom_range(300) * MS, $urandom_range(300) * MS,
					$urandom_range(5), $urandom_range(1), $urandom_range(63));
				5: configure({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
				default: configure($urandom_range(10, 200) * MS, $urandom_range(10, 200) * MS,
					$urandom_range(4), $urandom_range(1), $urandom_range(63));
			endcase
			steady = (phase == 4);
			if (phase == 6)
				base_ns = TIME_MAX - 20 * MS * PHASE_ITEMS;
			pending_ticks.push_back(make_tick(base_ns, F_RUN | F_BEGIN, 0));
			repeat (PHASE_ITEMS) pending_ticks.push_back(random_tick());
			drain();
		end

		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
